>>> rtl/lcd_sw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Stopwatch LCD writer package
// Shared types, codes, constants and the cursor-set and digit character helpers.
// ----------------------------------------------------------------------------
package lcd_sw_pkg;

  localparam int unsigned ROW_BASE_W = 7;
  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned NUM_ROWS = 4;
  localparam int unsigned REFRESH_CHARS = 7;

  localparam logic [ROW_BASE_W-1:0] ROW_ZERO_BASE_RST = 7'd0;
  localparam logic [ROW_BASE_W-1:0] ROW_ONE_BASE_RST = 7'd64;
  localparam logic [ROW_BASE_W-1:0] ROW_TWO_BASE_RST = 7'd16;
  localparam logic [ROW_BASE_W-1:0] ROW_THREE_BASE_RST = 7'd80;

  localparam logic [7:0] SET_ADDR_CMD = 8'h80;
  localparam logic [7:0] CLEAR_CMD = 8'h01;
  localparam logic [7:0] DIGIT_ZERO = 8'h30;
  localparam logic [7:0] COLON_CHAR = 8'h3A;
  localparam logic [7:0] POINT_CHAR = 8'h2E;
  localparam logic [3:0] LAST_COL = 4'd15;

  // Where the refresh writes the time
  localparam logic [1:0] TIME_ROW = 2'd3;
  localparam logic [3:0] TIME_COL = 4'd9;

  // Beat index of the final write of each kind of job, and of the refresh wrap
  localparam logic [3:0] REFRESH_LAST_IDX = 4'd15;
  localparam logic [3:0] REFRESH_WRAP_IDX = 4'd14;
  localparam logic [3:0] PUT_CHAR_LAST_IDX = 4'd1;
  localparam logic [3:0] SINGLE_LAST_IDX = 4'd0;

  // Register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] CFG_ROW_ZERO_BASE = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROW_THREE_BASE = 8'd3;

  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_HALT     = 3'd1,
    OP_RESUME   = 3'd2,
    OP_ZERO     = 3'd3,
    OP_REFRESH  = 3'd4,
    OP_PUT_CHAR = 3'd5,
    OP_GOTO     = 3'd6,
    OP_CLEAR    = 3'd7
  } opcode_t;

  typedef struct packed {
    logic tick;
    logic halt;
    logic resume;
    logic zero;
  } timer_ctrl_t;

  // Minute tens can reach ten, since the count runs to 109 minutes
  typedef struct packed {
    logic [3:0] min_tens;
    logic [3:0] min_units;
    logic [2:0] sec_tens;
    logic [3:0] sec_units;
    logic [3:0] tenths;
  } time_digits_t;

  function automatic logic [7:0] set_cmd(input logic [ROW_BASE_W-1:0] base,
                                         input logic [3:0] col);
    logic [7:0] addr;
    addr = 8'({1'b0, base}) + 8'({4'b0, col});
    return 8'(SET_ADDR_CMD + addr);
  endfunction

  function automatic logic [7:0] digit_char(input logic [3:0] digit);
    return 8'(DIGIT_ZERO + 8'({4'b0, digit}));
  endfunction

endpackage
`default_nettype wire

>>> rtl/lcd_sw_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Command channel
// Valid/ready channel carrying one stopwatch or LCD command per beat.
// ----------------------------------------------------------------------------
interface lcd_sw_in_if
  import lcd_sw_pkg::*;
();
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic [7:0] char_code;
  logic [2:0] target_row;
  logic [3:0] target_col;

  modport source (output valid, opcode, char_code, target_row, target_col,
                  input ready);
  modport sink (input valid, opcode, char_code, target_row, target_col,
                output ready);
endinterface
`default_nettype wire

>>> rtl/lcd_sw_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LCD write channel
// Valid/ready channel carrying one controller write per beat.
// ----------------------------------------------------------------------------
interface lcd_sw_out_if
  import lcd_sw_pkg::*;
();
  logic       valid;
  logic       ready;
  logic       reg_select;
  logic [7:0] bus_byte;
  logic       last_write;

  modport source (output valid, reg_select, bus_byte, last_write,
                  input ready);
  modport sink (input valid, reg_select, bus_byte, last_write,
                output ready);
endinterface
`default_nettype wire

>>> rtl/lcd_sw_cfg_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface lcd_sw_cfg_if
  import lcd_sw_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [ROW_BASE_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> rtl/lcd_sw_timer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Stopwatch timer
// Tenths counter driven by overflow ticks, kept alongside decimal digits.
// ----------------------------------------------------------------------------
module lcd_sw_timer
  import lcd_sw_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire timer_ctrl_t ctrl,
  output logic             half_flag,
  output time_digits_t     digits
);

  logic        halted;
  logic [15:0] tenths_count;

  // The digits follow the binary count, so a refresh needs no division.
  always_ff @(posedge clk) begin
    if (rst) begin
      halted       <= 1'b0;
      half_flag    <= 1'b0;
      tenths_count <= '0;
      digits       <= '0;
    end else begin
      if (ctrl.halt) begin
        halted <= 1'b1;
      end
      if (ctrl.resume) begin
        halted <= 1'b0;
      end
      if (ctrl.zero) begin
        tenths_count <= '0;
        digits       <= '0;
      end
      if (ctrl.tick && !halted) begin
        half_flag <= !half_flag;
        if (half_flag) begin
          if (tenths_count == 16'hFFFF) begin
            tenths_count <= '0;
            digits       <= '0;
          end else begin
            tenths_count <= 16'(tenths_count + 16'd1);
            if (digits.tenths != 4'd9) begin
              digits.tenths <= 4'(digits.tenths + 4'd1);
            end else begin
              digits.tenths <= '0;
              if (digits.sec_units != 4'd9) begin
                digits.sec_units <= 4'(digits.sec_units + 4'd1);
              end else begin
                digits.sec_units <= '0;
                if (digits.sec_tens != 3'd5) begin
                  digits.sec_tens <= 3'(digits.sec_tens + 3'd1);
                end else begin
                  digits.sec_tens <= '0;
                  if (digits.min_units != 4'd9) begin
                    digits.min_units <= 4'(digits.min_units + 4'd1);
                  end else begin
                    digits.min_units <= '0;
                    digits.min_tens  <= 4'(digits.min_tens + 4'd1);
                  end
                end
              end
            end
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/lcd_stopwatch_writer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Stopwatch LCD writer
// Stopwatch with a write sequencer for a character LCD controller.
// ----------------------------------------------------------------------------
// Writes pass the job register, then the output register. Throughput: one LCD
// write per cycle while the LCD is ready. A command of n writes (refresh 16,
// put char 2, goto and clear 1) holds the command channel until its last write
// moves on; commands that write nothing are taken one per cycle while no job
// is held. Reset: synchronous; the counter, flags and cursor clear and the row
// bases return to 0, 64, 16 and 80.
module lcd_stopwatch_writer
  import lcd_sw_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst,
  lcd_sw_cfg_if.sink   cfg,
  lcd_sw_in_if.sink    cmd,
  lcd_sw_out_if.source lcd
);

  logic [ROW_BASE_W-1:0] row_base [NUM_ROWS];
  logic [1:0]            cursor_row;
  logic [3:0]            cursor_col;

  // Job register: the command being turned into LCD writes
  logic       job_valid;
  opcode_t    job_op;
  logic [3:0] job_idx;
  logic [7:0] job_char;
  logic [1:0] job_row;
  logic [3:0] job_col;
  logic [7:0] job_chars [REFRESH_CHARS];

  // Output register
  logic       out_valid;
  logic       out_rs;
  logic [7:0] out_byte;
  logic       out_last;

  timer_ctrl_t  timer_ctrl;
  logic         half_flag;
  time_digits_t digits;

  opcode_t    in_op;
  logic       cmd_beat;
  logic       cmd_emits;
  logic       out_advance;
  logic [3:0] job_last_idx;
  logic       job_done;

  logic       beat_data;
  logic       beat_clear;
  logic [7:0] beat_char;
  logic [1:0] set_row;
  logic [3:0] set_col;
  logic [7:0] beat_byte;

  lcd_sw_timer u_timer (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (timer_ctrl),
    .half_flag (half_flag),
    .digits    (digits)
  );

  assign in_op = opcode_t'(cmd.opcode);
  assign cmd_beat = cmd.valid && cmd.ready;

  always_comb begin
    timer_ctrl.tick   = cmd_beat && (in_op == OP_TICK);
    timer_ctrl.halt   = cmd_beat && (in_op == OP_HALT);
    timer_ctrl.resume = cmd_beat && (in_op == OP_RESUME);
    timer_ctrl.zero   = cmd_beat && (in_op == OP_ZERO);
  end

  always_comb begin
    case (in_op)
      OP_REFRESH:  cmd_emits = half_flag;
      OP_PUT_CHAR: cmd_emits = 1'b1;
      OP_GOTO:     cmd_emits = !cmd.target_row[2];
      OP_CLEAR:    cmd_emits = 1'b1;
      default:     cmd_emits = 1'b0;
    endcase
  end

  always_comb begin
    case (job_op)
      OP_REFRESH:  job_last_idx = REFRESH_LAST_IDX;
      OP_PUT_CHAR: job_last_idx = PUT_CHAR_LAST_IDX;
      default:     job_last_idx = SINGLE_LAST_IDX;
    endcase
  end

  assign out_advance = !out_valid || lcd.ready;
  assign job_done = job_valid && out_advance && (job_idx == job_last_idx);
  assign cmd.ready = !job_valid || job_done;
  assign cfg.ready = 1'b1;

  // A refresh alternates characters with cursor moves along row 3; the
  // seventh character sits in column 15, so the cursor wraps to row 0.
  always_comb begin
    beat_data  = 1'b0;
    beat_clear = 1'b0;
    beat_char  = job_char;
    set_row    = job_row;
    set_col    = job_col;
    case (job_op)
      OP_REFRESH: begin
        if (job_idx == REFRESH_LAST_IDX) begin
          set_row = job_row;
          set_col = job_col;
        end else if (job_idx[0]) begin
          beat_data = 1'b1;
          beat_char = job_chars[job_idx[3:1]];
        end else if (job_idx == REFRESH_WRAP_IDX) begin
          set_row = 2'd0;
          set_col = 4'd0;
        end else begin
          set_row = TIME_ROW;
          set_col = 4'(TIME_COL + {1'b0, job_idx[3:1]});
        end
      end
      OP_PUT_CHAR: begin
        beat_data = (job_idx == SINGLE_LAST_IDX);
      end
      OP_GOTO: begin
        beat_data = 1'b0;
      end
      default: begin
        beat_clear = 1'b1;
      end
    endcase
  end

  always_comb begin
    if (beat_data) begin
      beat_byte = beat_char;
    end else if (beat_clear) begin
      beat_byte = CLEAR_CMD;
    end else begin
      beat_byte = set_cmd(row_base[set_row], set_col);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_base[0] <= ROW_ZERO_BASE_RST;
      row_base[1] <= ROW_ONE_BASE_RST;
      row_base[2] <= ROW_TWO_BASE_RST;
      row_base[3] <= ROW_THREE_BASE_RST;
      cursor_row  <= '0;
      cursor_col  <= '0;
      job_valid   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready && cfg.index <= CFG_ROW_THREE_BASE) begin
        row_base[cfg.index[1:0]] <= cfg.data;
      end

      if (out_advance) begin
        out_valid <= job_valid;
        if (job_valid) begin
          out_rs   <= beat_data;
          out_byte <= beat_byte;
          out_last <= (job_idx == job_last_idx);
        end
      end

      if (job_done) begin
        job_valid <= 1'b0;
      end else if (job_valid && out_advance) begin
        job_idx <= 4'(job_idx + 4'd1);
      end

      if (cmd_beat && cmd_emits) begin
        job_valid <= 1'b1;
        job_op    <= in_op;
        job_idx   <= '0;
        job_char  <= cmd.char_code;
        case (in_op)
          OP_PUT_CHAR: begin
            // The stored position is where the cursor lands after the byte
            if (cursor_col >= LAST_COL) begin
              job_row    <= 2'(cursor_row + 2'd1);
              job_col    <= '0;
              cursor_row <= 2'(cursor_row + 2'd1);
              cursor_col <= '0;
            end else begin
              job_row    <= cursor_row;
              job_col    <= 4'(cursor_col + 4'd1);
              cursor_col <= 4'(cursor_col + 4'd1);
            end
          end
          OP_GOTO: begin
            job_row    <= cmd.target_row[1:0];
            job_col    <= cmd.target_col;
            cursor_row <= cmd.target_row[1:0];
            cursor_col <= cmd.target_col;
          end
          default: begin
            job_row <= cursor_row;
            job_col <= cursor_col;
          end
        endcase
        job_chars[0] <= digit_char(digits.min_tens);
        job_chars[1] <= digit_char(digits.min_units);
        job_chars[2] <= COLON_CHAR;
        job_chars[3] <= digit_char({1'b0, digits.sec_tens});
        job_chars[4] <= digit_char(digits.sec_units);
        job_chars[5] <= POINT_CHAR;
        job_chars[6] <= digit_char(digits.tenths);
      end
    end
  end

  assign lcd.valid      = out_valid;
  assign lcd.reg_select = out_rs;
  assign lcd.bus_byte   = out_byte;
  assign lcd.last_write = out_last;

endmodule
`default_nettype wire

>>> test/lcd_stopwatch_writer_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Stopwatch LCD writer checker
// Watches the configuration, command and LCD write channels. It keeps its own
// copy of the stopwatch and cursor state, works out the LCD writes that each
// accepted command must cause, and compares every write beat against the
// oldest outstanding one, field by field.
// ----------------------------------------------------------------------------
module lcd_stopwatch_writer_checker
  import lcd_sw_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  lcd_sw_cfg_if  cfg,
  lcd_sw_in_if   cmd,
  lcd_sw_out_if  lcd,
  output int     mismatches,
  output int     writes_pending
);

  typedef struct packed {
    logic       reg_select;
    logic [7:0] bus_byte;
    logic       last_write;
  } lcd_write_t;

  lcd_write_t lcd_writes_q [$];

  // Predicted block state
  logic [ROW_BASE_W-1:0] row_base [NUM_ROWS];
  logic                  halted;
  logic                  half_flag;
  logic [15:0]           tenths_count;
  logic [1:0]            cursor_row;
  logic [3:0]            cursor_col;

  // The newest write of a command is held back so that it can be marked last.
  lcd_write_t held_write;
  logic       held_valid;
  int         fail_count;

  function automatic void stage_write(input logic rs, input logic [7:0] value);
    if (held_valid) lcd_writes_q.push_back(held_write);
    held_write = '{reg_select: rs, bus_byte: value, last_write: 1'b0};
    held_valid = 1'b1;
  endfunction

  function automatic void place_cursor(input logic [1:0] row, input logic [3:0] col);
    logic [7:0] addr;
    addr = 8'(row_base[row]) + 8'(col);
    cursor_row = row;
    cursor_col = col;
    stage_write(1'b0, 8'(SET_ADDR_CMD + addr));
  endfunction

  function automatic void write_char(input logic [7:0] ch);
    stage_write(1'b1, ch);
    if (cursor_col >= LAST_COL) place_cursor(2'(cursor_row + 2'd1), 4'd0);
    else place_cursor(cursor_row, 4'(cursor_col + 4'd1));
  endfunction

  function automatic void predict_lcd_writes(input opcode_t op, input logic [7:0] ch,
                                             input logic [2:0] row, input logic [3:0] col);
    int unsigned minutes;
    int unsigned rest;
    int unsigned secs;
    logic [1:0]  saved_row;
    logic [3:0]  saved_col;
    held_valid = 1'b0;
    case (op)
      OP_TICK: begin
        if (!halted) begin
          if (half_flag) begin
            half_flag = 1'b0;
            tenths_count = tenths_count + 16'd1;
          end else begin
            half_flag = 1'b1;
          end
        end
      end
      OP_HALT:   halted = 1'b1;
      OP_RESUME: halted = 1'b0;
      OP_ZERO:   tenths_count = '0;
      OP_REFRESH: begin
        if (half_flag) begin
          saved_row = cursor_row;
          saved_col = cursor_col;
          minutes = tenths_count / 600;
          rest = tenths_count % 600;
          secs = rest / 10;
          place_cursor(TIME_ROW, TIME_COL);
          write_char(8'(DIGIT_ZERO + minutes / 10));
          write_char(8'(DIGIT_ZERO + minutes % 10));
          write_char(COLON_CHAR);
          write_char(8'(DIGIT_ZERO + secs / 10));
          write_char(8'(DIGIT_ZERO + secs % 10));
          write_char(POINT_CHAR);
          write_char(8'(DIGIT_ZERO + rest % 10));
          place_cursor(saved_row, saved_col);
        end
      end
      OP_PUT_CHAR: write_char(ch);
      OP_GOTO: begin
        // Rows above three leave the cursor alone and write nothing.
        if (row < 3'(NUM_ROWS)) place_cursor(row[1:0], col);
      end
      OP_CLEAR: stage_write(1'b0, CLEAR_CMD);
      default: ;
    endcase
    if (held_valid) begin
      held_write.last_write = 1'b1;
      lcd_writes_q.push_back(held_write);
      held_valid = 1'b0;
    end
  endfunction

  function automatic void check_write(input logic rs, input logic [7:0] value,
                                      input logic last);
    lcd_write_t due;
    if (lcd_writes_q.size() == 0) begin
      $error("LCD write beat with nothing outstanding: reg_select %0d bus_byte %02h last_write %0d",
             rs, value, last);
      fail_count++;
    end else begin
      due = lcd_writes_q.pop_front();
      if (due.reg_select !== rs) begin
        $error("reg_select: expected %0d, got %0d", due.reg_select, rs);
        fail_count++;
      end
      if (due.bus_byte !== value) begin
        $error("bus_byte: expected %02h, got %02h", due.bus_byte, value);
        fail_count++;
      end
      if (due.last_write !== last) begin
        $error("last_write: expected %0d, got %0d", due.last_write, last);
        fail_count++;
      end
    end
  endfunction

  initial fail_count = 0;

  always @(posedge clk) begin
    if (rst) begin
      row_base[0] = ROW_ZERO_BASE_RST;
      row_base[1] = ROW_ONE_BASE_RST;
      row_base[2] = ROW_TWO_BASE_RST;
      row_base[3] = ROW_THREE_BASE_RST;
      halted = 1'b0;
      half_flag = 1'b0;
      tenths_count = '0;
      cursor_row = '0;
      cursor_col = '0;
      held_valid = 1'b0;
      lcd_writes_q.delete();
    end else begin
      if (lcd.valid && lcd.ready) check_write(lcd.reg_select, lcd.bus_byte, lcd.last_write);
      // Writes to indexes beyond the last row are dropped by the block.
      if (cfg.valid && cfg.ready && cfg.index < CFG_INDEX_W'(NUM_ROWS))
        row_base[cfg.index[1:0]] = cfg.data;
      if (cmd.valid && cmd.ready)
        predict_lcd_writes(opcode_t'(cmd.opcode), cmd.char_code, cmd.target_row,
                           cmd.target_col);
    end
    writes_pending <= lcd_writes_q.size();
    mismatches <= fail_count;
  end

endmodule

>>> test/lcd_stopwatch_writer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Stopwatch LCD writer testbench
// Drives commands and row base writes into the block with random gaps and
// back-pressure, including a long LCD hold-off, and reports the verdict from
// the checker's mismatch and pending write counts.
// ----------------------------------------------------------------------------
module lcd_stopwatch_writer_tb;
  import lcd_sw_pkg::*;

  localparam int HOLD_CYCLES    = 80;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_GAP      = 4;
  localparam int SETTLE_CYCLES  = 8;

  logic clk = 1'b0;
  logic rst;
  logic send_gaps;
  logic ready_gaps;
  logic hold_req;
  int   mismatches;
  int   writes_pending;
  int   idle_cycles;

  lcd_sw_cfg_if cfg ();
  lcd_sw_in_if  cmd ();
  lcd_sw_out_if lcd ();

  lcd_stopwatch_writer uut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .cmd (cmd),
    .lcd (lcd)
  );

  lcd_stopwatch_writer_checker write_check (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .cmd            (cmd),
    .lcd            (lcd),
    .mismatches     (mismatches),
    .writes_pending (writes_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // LCD side: random stalls, or a long hold-off the first time one is requested.
  initial begin
    logic hold_done;
    hold_done = 1'b0;
    lcd.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        lcd.ready <= 1'b0;
        hold_done = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      lcd.ready <= ready_gaps ? ($urandom_range(99) >= 35) : 1'b1;
    end
  end

  // Ends the run if no beat is taken on any channel for too long.
  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((cmd.valid && cmd.ready) || (lcd.valid && lcd.ready) || (cfg.valid && cfg.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("FAILED: results differ");
    $finish;
  end

  // Called just after a rising edge; returns once ready reads high after an edge.
  task automatic send_cmd(input opcode_t op, input logic [7:0] ch = 8'h00,
                          input logic [2:0] row = 3'd0, input logic [3:0] col = 4'd0);
    while (send_gaps && $urandom_range(99) < 35) begin
      cmd.valid <= 1'b0;
      @(posedge clk);
    end
    cmd.valid      <= 1'b1;
    cmd.opcode     <= op;
    cmd.char_code  <= ch;
    cmd.target_row <= row;
    cmd.target_col <= col;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
  endtask

  task automatic send_random_cmd();
    opcode_t     op;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 20)      op = OP_TICK;
    else if (pick < 25) op = OP_HALT;
    else if (pick < 35) op = OP_RESUME;
    else if (pick < 38) op = OP_ZERO;
    else if (pick < 58) op = OP_REFRESH;
    else if (pick < 78) op = OP_PUT_CHAR;
    else if (pick < 90) op = OP_GOTO;
    else                op = OP_CLEAR;
    send_cmd(op, 8'($urandom_range(255)), 3'($urandom_range(7)), 4'($urandom_range(15)));
  endtask

  // Stops offering commands until every predicted write has come out, then
  // waits out a drain gap for commands that write nothing.
  task automatic pause_until_drained();
    cmd.valid <= 1'b0;
    @(posedge clk);
    while (writes_pending != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  task automatic write_row_bases(input logic [ROW_BASE_W-1:0] b0, input logic [ROW_BASE_W-1:0] b1,
                                 input logic [ROW_BASE_W-1:0] b2, input logic [ROW_BASE_W-1:0] b3);
    logic [ROW_BASE_W-1:0] vals [NUM_ROWS];
    vals = '{b0, b1, b2, b3};
    for (int i = 0; i < NUM_ROWS; i++) begin
      cfg.valid <= 1'b1;
      cfg.index <= CFG_ROW_ZERO_BASE + CFG_INDEX_W'(i);
      cfg.data  <= vals[i];
      @(posedge clk);
      while (!cfg.ready) @(posedge clk);
    end
    // An index past the last row must leave every base untouched.
    cfg.index <= CFG_ROW_THREE_BASE + CFG_INDEX_W'($urandom_range(1, 252));
    cfg.data  <= ROW_BASE_W'($urandom_range(127));
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
  endtask

  initial begin
    cmd.valid      <= 1'b0;
    cmd.opcode     <= OP_TICK;
    cmd.char_code  <= 8'h00;
    cmd.target_row <= 3'd0;
    cmd.target_col <= 4'd0;
    cfg.valid      <= 1'b0;
    cfg.index      <= CFG_ROW_ZERO_BASE;
    cfg.data       <= '0;
    send_gaps      <= 1'b1;
    ready_gaps     <= 1'b1;
    hold_req       <= 1'b0;
    rst            <= 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset row bases.
    send_cmd(OP_REFRESH);
    send_cmd(OP_TICK);
    send_cmd(OP_REFRESH);
    send_cmd(OP_PUT_CHAR, 8'h00);
    send_cmd(OP_PUT_CHAR, 8'hFF);
    send_cmd(OP_GOTO, 8'h00, 3'd0, 4'd15);
    send_cmd(OP_PUT_CHAR, 8'h41);
    send_cmd(OP_GOTO, 8'h00, 3'd3, 4'd15);
    send_cmd(OP_PUT_CHAR, 8'h5A);
    send_cmd(OP_GOTO, 8'h00, 3'd4, 4'd5);
    send_cmd(OP_GOTO, 8'hFF, 3'd7, 4'd15);
    send_cmd(OP_CLEAR);
    send_cmd(OP_HALT);
    send_cmd(OP_TICK);
    send_cmd(OP_TICK);
    send_cmd(OP_RESUME);
    send_cmd(OP_TICK);
    send_cmd(OP_TICK);
    send_cmd(OP_GOTO, 8'h00, 3'd2, 4'd3);
    send_cmd(OP_REFRESH);
    send_cmd(OP_ZERO);
    send_cmd(OP_REFRESH);

    // Largest bases, so that the cursor address overflows the byte.
    pause_until_drained();
    write_row_bases(7'd127, 7'd127, 7'd127, 7'd127);
    send_cmd(OP_GOTO, 8'h00, 3'd3, 4'd15);
    send_cmd(OP_PUT_CHAR, 8'h7E);
    send_cmd(OP_REFRESH);

    pause_until_drained();
    write_row_bases(7'd0, 7'd0, 7'd0, 7'd0);
    repeat (25) send_random_cmd();

    // A stretch with no idling on either side.
    pause_until_drained();
    write_row_bases(7'($urandom_range(127)), 7'($urandom_range(127)),
                    7'($urandom_range(127)), 7'($urandom_range(127)));
    send_gaps  <= 1'b0;
    ready_gaps <= 1'b0;
    repeat (25) send_random_cmd();

    // The LCD side holds off while commands keep coming, so the block fills.
    ready_gaps <= 1'b1;
    hold_req   <= 1'b1;
    send_cmd(OP_RESUME);
    repeat (20) begin
      case ($urandom_range(2))
        0:       send_cmd(OP_REFRESH);
        1:       send_cmd(OP_PUT_CHAR, 8'($urandom_range(255)));
        default: send_cmd(OP_GOTO, 8'h00, 3'($urandom_range(3)), 4'($urandom_range(15)));
      endcase
    end

    // Back at the reset bases, a short count from zero.
    pause_until_drained();
    write_row_bases(ROW_ZERO_BASE_RST, ROW_ONE_BASE_RST, ROW_TWO_BASE_RST, ROW_THREE_BASE_RST);
    send_gaps <= 1'b1;
    send_cmd(OP_RESUME);
    send_cmd(OP_ZERO);
    send_cmd(OP_TICK);
    send_cmd(OP_TICK);
    send_cmd(OP_REFRESH);
    send_cmd(OP_TICK);
    send_cmd(OP_REFRESH);

    pause_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && writes_pending == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

>>> files.f
rtl/lcd_sw_pkg.sv
rtl/lcd_sw_in_if.sv
rtl/lcd_sw_out_if.sv
rtl/lcd_sw_cfg_if.sv
rtl/lcd_sw_timer.sv
rtl/lcd_stopwatch_writer.sv
test/lcd_stopwatch_writer_checker.sv
test/lcd_stopwatch_writer_tb.sv
